// File: rtl/positional_ordered_list_top_assert.svh
// assertion macros used by the ordered list controller
`ifndef POSITIONAL_ORDERED_LIST_TOP_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define POL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define POL_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define POL_ASSERT(lbl, prop, msg)
`define POL_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: rtl/pol_pkg.sv
// types and constants of the ordered list block
package pol_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int REQ_W        = 3;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 7;
    localparam int ST_W         = 2;
    localparam int CNT_OUT_W    = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD_FRONT = 3'd0,
        REQ_ADD_BACK  = 3'd1,
        REQ_ADD_POS   = 3'd2,
        REQ_REM_FRONT = 3'd3,
        REQ_REM_BACK  = 3'd4,
        REQ_REM_POS   = 3'd5
    } req_code_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } pol_req_t;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] front_value;
        logic                    is_empty;
        logic [CNT_OUT_W-1:0]    element_count;
    } pol_rsp_t;

endpackage

// File: rtl/pol_ram.sv
// element store: one write port, one read port, registered read data
module pol_ram
    import pol_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF
)
(
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic signed [VAL_W-1:0]      rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic signed [VAL_W-1:0]      wr_data
);

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/pol_ctrl.sv
// request decode, shift sequencer and result register of the ordered list
`include "positional_ordered_list_top_assert.svh"

module pol_ctrl
    import pol_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  pol_req_t                      req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output pol_rsp_t                      rsp,
    output logic                          rd_en,
    output logic [$clog2(CAPACITY)-1:0]   rd_addr,
    input  logic signed [VAL_W-1:0]       rd_data,
    output logic                          wr_en,
    output logic [$clog2(CAPACITY)-1:0]   wr_addr,
    output logic signed [VAL_W-1:0]       wr_data
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_PUT,
        S_FETCH,
        S_LOAD
    } state_t;

    state_t                  state_reg,   state_next;
    logic [CW-1:0]           count_reg,   count_next;
    logic [CW-1:0]           mv_left_reg, mv_left_next;
    logic [AW-1:0]           rd_ptr_reg,  rd_ptr_next;
    logic [AW-1:0]           wa_reg,      wa_next;
    logic                    issued_reg,  issued_next;
    logic                    ins_reg,     ins_next;
    logic [AW-1:0]           put_addr_reg, put_addr_next;
    logic signed [VAL_W-1:0] put_val_reg, put_val_next;
    status_t                 status_reg,  status_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    pol_rsp_t                rsp_reg,     rsp_next;

    // request decode
    logic [CMPW-1:0] cnt_x;
    logic [CMPW-1:0] eff_pos;
    logic [CMPW-1:0] moves;
    logic [CMPW-1:0] rd_start;
    logic [CMPW-1:0] cnt_out_x;
    logic            is_ins;
    logic            is_rem;
    status_t         dec_status;

    always_comb
    begin
        cnt_x   = CMPW'(count_reg);
        is_ins  = 1'b0;
        is_rem  = 1'b0;
        eff_pos = '0;
        case (req.req_type)
            REQ_ADD_FRONT:
            begin
                is_ins = 1'b1;
            end
            REQ_ADD_BACK:
            begin
                is_ins  = 1'b1;
                eff_pos = cnt_x;
            end
            REQ_ADD_POS:
            begin
                is_ins  = 1'b1;
                eff_pos = CMPW'(req.position);
            end
            REQ_REM_FRONT:
            begin
                is_rem = 1'b1;
            end
            REQ_REM_BACK:
            begin
                is_rem  = 1'b1;
                eff_pos = cnt_x - CMPW'(1);
            end
            REQ_REM_POS:
            begin
                is_rem  = 1'b1;
                eff_pos = CMPW'(req.position);
            end
            default:
            begin
                is_ins = 1'b0;
            end
        endcase

        dec_status = ST_DONE;
        if (is_ins)
        begin
            if (eff_pos > cnt_x)
                dec_status = ST_RANGE;
            else if (cnt_x >= CMPW'(CAPACITY))
                dec_status = ST_FULL;
        end
        else if (is_rem)
        begin
            if (cnt_x == '0)
                dec_status = ST_EMPTY;
            else if (eff_pos >= cnt_x)
                dec_status = ST_RANGE;
        end

        // insert walks down from the back, remove walks up from behind the hole
        if (is_ins)
        begin
            moves    = cnt_x - eff_pos;
            rd_start = cnt_x - CMPW'(1);
        end
        else
        begin
            moves    = cnt_x - eff_pos - CMPW'(1);
            rd_start = eff_pos + CMPW'(1);
        end
    end

    // memory port drive
    always_comb
    begin
        rd_en   = ((state_reg == S_MOVE) && (mv_left_reg != '0)) || (state_reg == S_FETCH);
        rd_addr = (state_reg == S_FETCH) ? '0 : rd_ptr_reg;
        wr_en   = ((state_reg == S_MOVE) && issued_reg) || (state_reg == S_PUT);
        wr_addr = (state_reg == S_PUT) ? put_addr_reg : wa_reg;
        wr_data = (state_reg == S_PUT) ? put_val_reg : rd_data;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        mv_left_next   = mv_left_reg;
        rd_ptr_next    = rd_ptr_reg;
        wa_next        = wa_reg;
        issued_next    = 1'b0;
        ins_next       = ins_reg;
        put_addr_next  = put_addr_reg;
        put_val_next   = put_val_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        cnt_out_x      = CMPW'(count_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    status_next   = dec_status;
                    ins_next      = is_ins;
                    mv_left_next  = moves[CW-1:0];
                    rd_ptr_next   = rd_start[AW-1:0];
                    put_addr_next = eff_pos[AW-1:0];
                    put_val_next  = req.value;
                    if ((is_ins || is_rem) && (dec_status == ST_DONE))
                    begin
                        count_next = is_ins ? count_reg + CW'(1) : count_reg - CW'(1);
                        state_next = S_MOVE;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_MOVE:
            begin
                if (mv_left_reg != '0)
                begin
                    issued_next  = 1'b1;
                    mv_left_next = mv_left_reg - CW'(1);
                    rd_ptr_next  = ins_reg ? rd_ptr_reg - AW'(1) : rd_ptr_reg + AW'(1);
                    wa_next      = ins_reg ? rd_ptr_reg + AW'(1) : rd_ptr_reg - AW'(1);
                end
                else
                begin
                    // the last moved element is written in this cycle
                    state_next = ins_reg ? S_PUT : S_FETCH;
                end
            end
            S_PUT:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = status_reg;
                    rsp_next.is_empty     = (count_reg == '0);
                    rsp_next.front_value  = (count_reg == '0) ? {VAL_W{1'b1}} : rd_data;
                    rsp_next.element_count = cnt_out_x[CNT_OUT_W-1:0];
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mv_left_reg   <= '0;
            issued_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rd_ptr_reg    <= '0;
            wa_reg        <= '0;
            ins_reg       <= 1'b0;
            put_addr_reg  <= '0;
            put_val_reg   <= '0;
            status_reg    <= ST_DONE;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mv_left_reg   <= mv_left_next;
            issued_reg    <= issued_next;
            rsp_valid_reg <= rsp_valid_next;
            rd_ptr_reg    <= rd_ptr_next;
            wa_reg        <= wa_next;
            ins_reg       <= ins_next;
            put_addr_reg  <= put_addr_next;
            put_val_reg   <= put_val_next;
            status_reg    <= status_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `POL_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "element count above capacity")
    `POL_ASSERT(a_idle_no_write, (state_reg == S_IDLE) |-> !wr_en, "store written while idle")
    `POL_ASSERT(a_no_rw_clash, (rd_en && wr_en) |-> (rd_addr != wr_addr), "read and write hit same entry")
    `POL_ASSERT_NEXT(a_count_hold, state_reg != S_IDLE, $stable(count_reg), "count changed mid transaction")

endmodule

// File: rtl/positional_ordered_list_top.sv
// top level of the bounded ordered list
// Bounded ordered list of up to CAPACITY signed 32-bit values held in one
// single-port-write, single-port-read memory. One request is handled at a time:
// an insert or remove moves every element behind the affected position by one
// entry, one element per cycle through the memory's read and write ports; an
// insert then writes the new value, and every request, refused or ignored ones
// too, ends by reading the front element into the result.
// The result is held in an output register, so the next request may start while
// the previous result is still stalled.
module positional_ordered_list_top
    import pol_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  pol_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output pol_rsp_t rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic signed [VAL_W-1:0] rd_data;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [VAL_W-1:0] wr_data;

    pol_ram #(
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk    (clk),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    pol_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

endmodule
